// ----- rtl/lzsd_pkg.sv -----
// Package for the LZ77 stream decompressor: payload types, sizes and the
// command and status groups that join the controller to the datapath.
// No dependencies.
package lzsd_pkg;

   localparam int WINDOW_DEPTH = 4096;
   localparam int WIN_BITS     = $clog2(WINDOW_DEPTH);
   localparam int SIZE_BITS    = 24;
   localparam int BYTE_BITS    = 8;
   localparam int RUN_BITS     = 5;

   typedef logic [WIN_BITS-1:0]  win_addr_type;
   typedef logic [SIZE_BITS-1:0] size_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0] in_byte;
      logic                 stream_start;
   } req_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0] out_byte;
      logic                 run_last;
      logic                 stream_last;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic load_size0;
      logic load_size1;
      logic load_size2;
      logic load_code;
      logic emit_lit;
      logic start_copy;
      logic emit_copy;
   } cmd_type;

   typedef struct packed {
      logic slot_free;
      logic copy_last;
      logic size_reached;
   } status_type;

   typedef enum logic [8:0] {
      ST_TYPE   = 9'b000000001,
      ST_SIZE0  = 9'b000000010,
      ST_SIZE1  = 9'b000000100,
      ST_SIZE2  = 9'b000001000,
      ST_FLAG   = 9'b000010000,
      ST_UNIT   = 9'b000100000,
      ST_CODELO = 9'b001000000,
      ST_COPY   = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

endpackage

// ----- rtl/lzsd_ctrl.sv -----
// Controller of the LZ77 stream decompressor: parses the header, flag bytes
// and codewords, and sequences phrase copies. Depends on lzsd_pkg.
module lzsd_ctrl import lzsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_payload,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic [7:0] flag_bits_ff, flag_bits_in;
   logic [2:0] flag_count_ff, flag_count_in;
   logic       accept;
   logic       end_unit;
   logic [2:0] count_inc;

   assign req_ready = status.slot_free && (state_ff != ST_COPY);
   assign accept    = req_valid && req_ready;
   assign count_inc = flag_count_ff + 3'd1;

   always_comb begin
      state_in      = state_ff;
      flag_bits_in  = flag_bits_ff;
      flag_count_in = flag_count_ff;
      cmd           = '0;
      end_unit      = 1'b0;
      if (accept && req_payload.stream_start) begin
         cmd.clear     = 1'b1;
         state_in      = ST_SIZE0;
         flag_bits_in  = '0;
         flag_count_in = '0;
      end else if (accept) begin
         unique case (state_ff)
            ST_TYPE: begin
               state_in = ST_SIZE0;
            end
            ST_SIZE0: begin
               cmd.load_size0 = 1'b1;
               state_in       = ST_SIZE1;
            end
            ST_SIZE1: begin
               cmd.load_size1 = 1'b1;
               state_in       = ST_SIZE2;
            end
            ST_SIZE2: begin
               cmd.load_size2 = 1'b1;
               state_in       = ST_FLAG;
            end
            ST_FLAG: begin
               flag_bits_in  = req_payload.in_byte;
               flag_count_in = '0;
               state_in      = ST_UNIT;
            end
            ST_UNIT: begin
               if (!flag_bits_ff[7]) begin
                  cmd.emit_lit = 1'b1;
                  end_unit     = 1'b1;
               end else begin
                  cmd.load_code = 1'b1;
                  state_in      = ST_CODELO;
               end
            end
            ST_CODELO: begin
               cmd.start_copy = 1'b1;
               state_in       = ST_COPY;
            end
            ST_DONE: begin
               state_in = ST_DONE;
            end
            default: begin
               state_in = ST_TYPE;
            end
         endcase
      end else if (state_ff == ST_COPY && status.slot_free) begin
         cmd.emit_copy = 1'b1;
         end_unit      = status.copy_last;
      end

      // Closing a unit consumes one flag bit; the stream ends once the
      // produced count has reached the header size.
      if (end_unit) begin
         flag_bits_in  = {flag_bits_ff[6:0], 1'b0};
         flag_count_in = count_inc;
         if (status.size_reached) begin
            state_in = ST_DONE;
         end else if (count_inc == 3'd0) begin
            state_in = ST_FLAG;
         end else begin
            state_in = ST_UNIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_TYPE;
         flag_bits_ff  <= '0;
         flag_count_ff <= '0;
      end else begin
         state_ff      <= state_in;
         flag_bits_ff  <= flag_bits_in;
         flag_count_ff <= flag_count_in;
      end
   end

endmodule

// ----- rtl/lzsd_datapath.sv -----
// Datapath of the LZ77 stream decompressor: size and count registers, the
// history window memory with its read bypass, and the output register.
// Depends on lzsd_pkg.
module lzsd_datapath import lzsd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   input  logic [BYTE_BITS-1:0] in_byte,
   output status_type           status,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_payload
);

   logic [BYTE_BITS-1:0] hist_mem [WINDOW_DEPTH];

   size_type             target_ff, target_in;
   size_type             produced_ff, produced_in;
   size_type             produced_inc;
   win_addr_type         wp_ff, wp_in;
   win_addr_type         dist_m1_ff, dist_m1_in;
   logic [BYTE_BITS-1:0] code_high_ff, code_high_in;
   logic [RUN_BITS-1:0]  rem_ff, rem_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic [BYTE_BITS-1:0] rd_q_ff;
   logic [BYTE_BITS-1:0] fwd_data_ff;
   logic                 fwd_ff;

   logic                 emit;
   logic [BYTE_BITS-1:0] emit_byte;
   logic [BYTE_BITS-1:0] copy_byte;
   logic                 rd_en;
   win_addr_type         rd_addr;
   win_addr_type         start_dist;
   logic                 unit_last;

   assign produced_inc = (produced_ff == '1) ? produced_ff : produced_ff + size_type'(1);

   assign status.slot_free    = !rsp_valid_ff || rsp_ready;
   assign status.copy_last    = (rem_ff == '0);
   assign status.size_reached = (produced_inc >= target_ff);

   // A byte written in the same cycle as the read of its own address (a
   // distance of one) is taken from the bypass register instead of the memory.
   assign copy_byte = fwd_ff ? fwd_data_ff : rd_q_ff;
   assign emit      = cmd.emit_lit || cmd.emit_copy;
   assign emit_byte = cmd.emit_lit ? in_byte : copy_byte;
   assign unit_last = cmd.emit_lit || status.copy_last;

   assign start_dist = {code_high_ff[3:0], in_byte};
   assign rd_en      = cmd.start_copy || (cmd.emit_copy && !status.copy_last);
   assign rd_addr    = cmd.start_copy ? wp_ff - start_dist - win_addr_type'(1)
                                      : wp_ff - dist_m1_ff;

   always_comb begin
      target_in    = target_ff;
      produced_in  = produced_ff;
      wp_in        = wp_ff;
      dist_m1_in   = dist_m1_ff;
      code_high_in = code_high_ff;
      rem_in       = rem_ff;
      if (cmd.clear) begin
         target_in   = '0;
         produced_in = '0;
         wp_in       = '0;
      end
      if (cmd.load_size0) begin
         target_in = size_type'(in_byte);
      end
      if (cmd.load_size1) begin
         target_in = target_ff | size_type'({in_byte, 8'h00});
      end
      if (cmd.load_size2) begin
         target_in = target_ff | size_type'({in_byte, 16'h0000});
      end
      if (cmd.load_code) begin
         code_high_in = in_byte;
      end
      if (cmd.start_copy) begin
         dist_m1_in = start_dist;
         rem_in     = RUN_BITS'(code_high_ff[7:4]) + RUN_BITS'(2);
      end
      if (cmd.emit_copy) begin
         rem_in = rem_ff - RUN_BITS'(1);
      end
      if (emit) begin
         wp_in       = wp_ff + win_addr_type'(1);
         produced_in = produced_inc;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.out_byte    = emit_byte;
         rsp_data_in.run_last    = unit_last;
         rsp_data_in.stream_last = unit_last && status.size_reached;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= '0;
         produced_ff  <= '0;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         target_ff    <= target_in;
         produced_ff  <= produced_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_m1_ff   <= dist_m1_in;
      code_high_ff <= code_high_in;
      rem_ff       <= rem_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         hist_mem[wp_ff] <= emit_byte;
      end
      if (rd_en) begin
         rd_q_ff     <= hist_mem[rd_addr];
         fwd_ff      <= emit && (rd_addr == wp_ff);
         fwd_data_ff <= emit_byte;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

// ----- rtl/lz77_stream_decompressor_unit.sv -----
// Top level of the LZ77 stream decompressor (BIOS LZ77 format).
// Depends on lzsd_pkg, lzsd_ctrl and lzsd_datapath.
//
// This block takes a compressed stream one byte per request and returns the
// decompressed bytes one per response. A request with stream_start set opens
// a new stream and is taken as its type byte; three size bytes follow, least
// significant first, and then groups of a flag byte and eight units, flag bits
// read from the most significant end. Header bytes, flag bytes, literals and
// the first byte of a codeword are each taken when the response register is
// free to accept a result. After the second codeword byte, the phrase of 3 to
// 18 bytes drains at one byte per cycle while the response register is free,
// taking no request meanwhile; that rate is set by the single read port of
// the 4096-byte history window and the one-deep response register. Overlapping
// copies (distance one) are served by a bypass around the window memory.
// Each response marks run_last on the last byte produced by its request and
// stream_last on the final byte of the stream, after which further requests
// are consumed without response until the next stream_start. The history
// window is not cleared on reset or at a stream start; a phrase that reaches
// back before the current stream returns whatever the window holds.
module lz77_stream_decompressor_unit import lzsd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   cmd_type    cmd;
   status_type status;

   // The controller owns the parse state and flag bits and issues at most one command
   // per cycle; the datapath answers with response-slot and count status.
   lzsd_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .status      (status),
      .cmd         (cmd)
   );

   lzsd_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .in_byte     (req_payload.in_byte),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- bench/tb_lz77_stream_decompressor_unit.sv -----
// Self-checking testbench for lz77_stream_decompressor_unit: a directed opening, then random
// compressed streams under random request gaps and response stalls.
// Depends on lzsd_pkg and the RTL of the decompressor.
module tb_lz77_stream_decompressor_unit import lzsd_pkg::*; ();

   localparam int         CYCLE_LIMIT  = 500000;
   localparam int         RANDOM_REQS  = 330;
   localparam int         DRAIN_CYCLES = 40;
   localparam logic [7:0] TYPE_LZ77    = 8'h10;

   // Parse position of the expected-result predictor, one name per kind of byte.
   typedef enum logic [2:0] {
      DP_TYPE_BYTE,
      DP_SIZE_LO,
      DP_SIZE_MID,
      DP_SIZE_HI,
      DP_FLAGS,
      DP_UNIT,
      DP_CODE_LO,
      DP_FINISHED
   } decode_phase_type;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   lz77_stream_decompressor_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor state. It mirrors the decompressor as seen from its ports, including the
   // history window, which outlives every stream start.
   decode_phase_type pred_phase = DP_TYPE_BYTE;
   logic [7:0]    pred_flags    = '0;
   logic [2:0]    pred_unit_idx = '0;
   logic [7:0]    pred_code_hi  = '0;
   size_type      pred_size     = '0;
   size_type      pred_count    = '0;
   win_addr_type  pred_wp       = '0;
   bit            pred_done     = 1'b0;
   logic [7:0]    pred_window [WINDOW_DEPTH];
   bit            pred_written [WINDOW_DEPTH];

   // Requests waiting to be sent, with the number of decoded bytes each one releases and
   // whether the sender must first wait for every outstanding byte to come back.
   req_type req_backlog[$];
   int      backlog_bytes[$];
   bit      backlog_hold[$];
   // Decoded bytes of requests not yet accepted, and of accepted ones still to arrive.
   rsp_type decoded_bytes[$];
   rsp_type due_bytes[$];

   bit hold_next     = 1'b0;
   bit req_taken     = 1'b0;
   int cycle_count   = 0;
   int mismatches    = 0;
   int checked_bytes = 0;
   int useful_reqs   = 0;
   int ignored_reqs  = 0;
   int stream_count  = 0;

   // Writes one decoded byte into the window and appends it to the expected output.
   function automatic void emit_byte(logic [7:0] value);
      rsp_type produced;
      pred_window[pred_wp]  = value;
      pred_written[pred_wp] = 1'b1;
      pred_wp = pred_wp + 1'b1;
      if (pred_count != '1) pred_count = pred_count + 1'b1;
      produced.out_byte    = value;
      produced.run_last    = 1'b0;
      produced.stream_last = 1'b0;
      decoded_bytes.push_back(produced);
   endfunction

   // Steps to the next flag bit and reports whether the stream has reached its size.
   function automatic bit close_unit();
      pred_flags    = pred_flags << 1;
      pred_unit_idx = pred_unit_idx + 3'd1;
      pred_phase    = (pred_unit_idx == 3'd0) ? DP_FLAGS : DP_UNIT;
      if (pred_count >= pred_size) begin
         pred_done  = 1'b1;
         pred_phase = DP_FINISHED;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Decodes one request against the predictor state and returns how many bytes it yields.
   function automatic int decode_request(req_type r);
      int         produced;
      int         copy_len;
      int         copy_dist;
      bit         ended;
      rsp_type    tail;
      produced = 0;
      ended    = 1'b0;
      if (r.stream_start) begin
         // A start abandons whatever was in progress; only the window survives.
         pred_phase    = DP_SIZE_LO;
         pred_flags    = '0;
         pred_unit_idx = '0;
         pred_code_hi  = '0;
         pred_size     = '0;
         pred_count    = '0;
         pred_wp       = '0;
         pred_done     = 1'b0;
         return 0;
      end
      case (pred_phase)
         DP_TYPE_BYTE: pred_phase = DP_SIZE_LO;
         DP_SIZE_LO: begin
            pred_size  = size_type'(r.in_byte);
            pred_phase = DP_SIZE_MID;
         end
         DP_SIZE_MID: begin
            pred_size  = pred_size | (size_type'(r.in_byte) << 8);
            pred_phase = DP_SIZE_HI;
         end
         DP_SIZE_HI: begin
            pred_size  = pred_size | (size_type'(r.in_byte) << 16);
            pred_phase = DP_FLAGS;
         end
         DP_FLAGS: begin
            pred_flags    = r.in_byte;
            pred_unit_idx = '0;
            pred_phase    = DP_UNIT;
         end
         DP_UNIT: begin
            if (!pred_flags[7]) begin
               emit_byte(r.in_byte);
               produced = 1;
               ended    = close_unit();
            end else begin
               pred_code_hi = r.in_byte;
               pred_phase   = DP_CODE_LO;
            end
         end
         DP_CODE_LO: begin
            // Byte-by-byte copy, so a distance shorter than the length repeats the
            // bytes this same copy has just written.
            copy_len  = int'(pred_code_hi[7:4]) + 3;
            copy_dist = int'({pred_code_hi[3:0], r.in_byte}) + 1;
            for (int i = 0; i < copy_len; i++)
               emit_byte(pred_window[win_addr_type'(int'(pred_wp) - copy_dist)]);
            produced = copy_len;
            ended    = close_unit();
         end
         default: ;
      endcase
      if (produced > 0) begin
         tail = decoded_bytes.pop_back();
         tail.run_last    = 1'b1;
         tail.stream_last = ended;
         decoded_bytes.push_back(tail);
      end
      return produced;
   endfunction

   // True when a copy of this length and distance reads only window entries written
   // at some point, so no never-written entry is ever fetched.
   function automatic bit copy_fits(int len, int back_dist);
      for (int i = 0; i < len && i < back_dist; i++)
         if (!pred_written[win_addr_type'(int'(pred_wp) - back_dist + i)]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void queue_request(logic [7:0] value, bit start);
      req_type r;
      r.in_byte      = value;
      r.stream_start = start;
      if (!start && pred_phase == DP_FINISHED) ignored_reqs++;
      else useful_reqs++;
      if (start) stream_count++;
      req_backlog.push_back(r);
      backlog_bytes.push_back(decode_request(r));
      backlog_hold.push_back(hold_next);
      hold_next = 1'b0;
   endfunction

   // Appends flag bytes, literals and codewords until the stream ends or the step budget
   // runs out; a negative budget means run to the end of the stream.
   function automatic void queue_units(int limit);
      int          steps;
      int          len;
      int          back_dist;
      bit          fits;
      logic [7:0]  flags;
      logic [15:0] code;
      steps = 0;
      while (!pred_done && (limit < 0 || steps < limit)) begin
         steps++;
         if (pred_phase == DP_FLAGS) begin
            case ($urandom_range(0, 5))
               0:       flags = 8'h00;
               1:       flags = 8'hFF;
               default: flags = 8'($urandom);
            endcase
            // With nothing written behind the pointer, the next unit has to be a literal.
            if (!copy_fits(3, 1) && !copy_fits(3, WINDOW_DEPTH)) flags[7] = 1'b0;
            queue_request(flags, 1'b0);
         end else if (!pred_flags[7]) begin
            queue_request(8'($urandom), 1'b0);
         end else begin
            fits = 1'b0;
            for (int tries = 0; tries < 6 && !fits; tries++) begin
               len = $urandom_range(3, 18);
               case ($urandom_range(0, 3))
                  0:       back_dist = $urandom_range(1, 4);
                  1:       back_dist = $urandom_range(1, 64);
                  2:       back_dist = $urandom_range(1, WINDOW_DEPTH);
                  default: back_dist = WINDOW_DEPTH - $urandom_range(0, 31);
               endcase
               fits = copy_fits(len, back_dist);
            end
            if (!fits) begin
               len       = 3;
               back_dist = copy_fits(3, 1) ? 1 : WINDOW_DEPTH;
            end
            code = 16'(((len - 3) << 12) | (back_dist - 1));
            queue_request(code[15:8], 1'b0);
            queue_request(code[7:0], 1'b0);
         end
      end
   endfunction

   // Sender: requests come in bursts of random length separated by random gaps. Some
   // bursts have no gap at all, and a flagged request waits until the output has drained.
   int burst_left = 0;
   int gap_left   = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (req_backlog.size() == 0 ||
                      (backlog_hold[0] && due_bytes.size() != 0)) begin
            req_valid <= 1'b0;
         end else begin
            req_valid   <= 1'b1;
            req_payload <= req_backlog[0];
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
      end
   end

   // Receiver: ready follows a rotating 16-bit pattern that is reloaded every so often.
   // Bit 0 is always set on reload, so every stall ends before the pattern has rotated once.
   logic [15:0] ready_pattern = '1;
   int          pattern_age   = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (pattern_age == 0) begin
            case ($urandom_range(0, 3))
               0:       ready_pattern = '1;
               1:       ready_pattern = 16'($urandom) | 16'h0001;
               2:       ready_pattern = 16'h0101;
               default: ready_pattern = (16'($urandom) & 16'($urandom)) | 16'h0001;
            endcase
            pattern_age = $urandom_range(8, 64);
         end
         pattern_age--;
         rsp_ready     <= ready_pattern[0];
         ready_pattern  = {ready_pattern[0], ready_pattern[15:1]};
      end
   end

   // Monitor: an accepted request releases its predicted bytes into the due list, and every
   // accepted response is checked against the oldest due byte.
   always @(posedge clock) begin : response_monitor
      int      released;
      rsp_type want;
      cycle_count++;
      if (!reset) begin
         if (req_valid && req_ready) begin
            released = backlog_bytes.pop_front();
            req_backlog.delete(0);
            backlog_hold.delete(0);
            repeat (released) due_bytes.push_back(decoded_bytes.pop_front());
            req_taken = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            checked_bytes++;
            if (due_bytes.size() == 0) begin
               $error("unexpected response, out_byte %0h", rsp_payload.out_byte);
               mismatches++;
            end else begin
               want = due_bytes.pop_front();
               if (rsp_payload.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %0h, actual %0h",
                         want.out_byte, rsp_payload.out_byte);
                  mismatches++;
               end
               if (rsp_payload.run_last !== want.run_last) begin
                  $error("run_last: expected %0b, actual %0b",
                         want.run_last, rsp_payload.run_last);
                  mismatches++;
               end
               if (rsp_payload.stream_last !== want.stream_last) begin
                  $error("stream_last: expected %0b, actual %0b",
                         want.stream_last, rsp_payload.stream_last);
                  mismatches++;
               end
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("tb_lz77_stream_decompressor_unit: errors");
      $finish;
   end

   initial begin
      int       random_from;
      int       cut;
      size_type stream_size;

      // Right after reset the block is in its type phase, so this type byte is taken
      // without stream_start. Three literals, two of them of extreme values, then a byte that
      // arrives after the end and must be ignored.
      queue_request(TYPE_LZ77, 1'b0);
      queue_request(8'h03, 1'b0);
      queue_request(8'h00, 1'b0);
      queue_request(8'h00, 1'b0);
      queue_request(8'h00, 1'b0);
      queue_request(8'h00, 1'b0);
      queue_request(8'hFF, 1'b0);
      queue_request(8'h5A, 1'b0);
      queue_request(8'hFF, 1'b0);

      // Largest size, all codewords. The first copy uses the largest distance, which
      // from a write pointer of zero reaches the bytes of the previous stream. Then the
      // longest copy at distance one and the shortest one, and the stream is abandoned.
      hold_next = 1'b1;
      queue_request(TYPE_LZ77, 1'b1);
      queue_request(8'hFF, 1'b0);
      queue_request(8'hFF, 1'b0);
      queue_request(8'hFF, 1'b0);
      queue_request(8'hFF, 1'b0);
      queue_request(8'h0F, 1'b0);
      queue_request(8'hFF, 1'b0);
      queue_request(8'hF0, 1'b0);
      queue_request(8'h00, 1'b0);
      queue_request(8'h00, 1'b0);
      queue_request(8'h00, 1'b0);

      // Zero size: the first unit, a far-reaching codeword, is still decoded.
      hold_next = 1'b1;
      queue_request(TYPE_LZ77, 1'b1);
      queue_request(8'h00, 1'b0);
      queue_request(8'h00, 1'b0);
      queue_request(8'h00, 1'b0);
      queue_request(8'h80, 1'b0);
      queue_request(8'h0F, 1'b0);
      queue_request(8'hFF, 1'b0);

      // Random part: mostly complete streams of small size with a few long ones, the rest
      // cut off at a random point by the next stream start. Bytes after a finished
      // stream are thrown in now and then.
      random_from = useful_reqs;
      while (useful_reqs - random_from < RANDOM_REQS) begin
         hold_next = ($urandom_range(0, 7) == 0);
         queue_request(8'($urandom), 1'b1);
         if ($urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 9))
               7, 8:    stream_size = size_type'($urandom_range(41, 200));
               9:       stream_size = size_type'($urandom_range(201, 700));
               default: stream_size = size_type'($urandom_range(0, 40));
            endcase
            for (int k = 0; k < 3; k++) queue_request(stream_size[8*k +: 8], 1'b0);
            queue_units(-1);
            repeat ($urandom_range(0, 2)) queue_request(8'($urandom), 1'b0);
         end else begin
            stream_size = size_type'($urandom);
            cut         = $urandom_range(0, 3);
            for (int k = 0; k < cut; k++) queue_request(stream_size[8*k +: 8], 1'b0);
            if (cut == 3) queue_units($urandom_range(0, 14));
         end
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || due_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d streams from %0d requests, %0d of them dropped after a stream end.",
               stream_count, useful_reqs + ignored_reqs, ignored_reqs);
      $display("Checked %0d decoded bytes under random request gaps and response stalls.",
               checked_bytes);
      if (mismatches == 0 && due_bytes.size() == 0) begin
         $display("tb_lz77_stream_decompressor_unit: clean");
      end else begin
         $display("tb_lz77_stream_decompressor_unit: errors");
      end
      $finish;
   end

endmodule
